// File: hdl/srsp_pkg.sv
// ----------------------------------------------------------------------------
// srsp_pkg - shared types and constants for the sign record stream parser
// Parse phases, record and group codes, register indexes and the result
// record carried through the output stage.
// ----------------------------------------------------------------------------
package srsp_pkg;

  typedef enum logic [2:0] {
    PH_HEADER     = 3'd0,
    PH_CUR_SPEED  = 3'd1,
    PH_NEXT_BODY  = 3'd2,
    PH_COUNT      = 3'd3,
    PH_ENTRY_BODY = 3'd4
  } phase_t;

  // record_kind codes
  localparam logic [2:0] KIND_CUR_SPEED  = 3'd0;
  localparam logic [2:0] KIND_NEXT_SPEED = 3'd1;
  localparam logic [2:0] KIND_GROUP_HDR  = 3'd2;
  localparam logic [2:0] KIND_SIGN_ENTRY = 3'd3;
  localparam logic [2:0] KIND_END_ONLY   = 3'd4;

  // group_kind codes
  localparam logic [1:0] GRP_CAMERA  = 2'd0;
  localparam logic [1:0] GRP_TRAFFIC = 2'd1;
  localparam logic [1:0] GRP_OTHER   = 2'd2;

  // register indexes
  localparam int unsigned NUM_CODES = 5;
  localparam logic [2:0] REG_CUR_SPEED  = 3'd0;
  localparam logic [2:0] REG_NEXT_SPEED = 3'd1;
  localparam logic [2:0] REG_CAMERA     = 3'd2;
  localparam logic [2:0] REG_TRAFFIC    = 3'd3;
  localparam logic [2:0] REG_OTHER      = 3'd4;

  // six-byte body: id (3), code/speed, distance high, distance low
  localparam logic [2:0] ID_BYTES      = 3'd3;
  localparam logic [2:0] POS_CODE      = 3'd3;
  localparam logic [2:0] POS_DIST_HIGH = 3'd4;
  localparam logic [2:0] BODY_LAST_POS = 3'd5;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [1:0]  group_kind;
    logic [23:0] sign_id;
    logic [7:0]  value_byte;
    logic [15:0] distance;
    logic        message_end;
    logic        truncated;
  } result_t;

endpackage

// File: hdl/sign_record_stream_parser.sv
// ----------------------------------------------------------------------------
// sign_record_stream_parser - byte-serial parser for header-tagged sign records
// Takes one message byte per transaction and emits one result per completed
// record, group header or group entry, and marks the message end on the last byte.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------
//  input    | in        | in_valid / in_stall   | data_byte, last_byte
//  result   | out       | out_valid / out_stall | record_kind, group_kind,
//           |           |                       | sign_id, value_byte, distance,
//           |           |                       | message_end, truncated
//  config   | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One byte is taken every cycle while in_stall is low; the parse state
//  updates in that cycle, and its result is registered in the output stage.
//  A skid register holds one result while out_stall is high; in_stall rises
//  only when both output register and skid register are occupied.
//  rst is synchronous: parse state returns to expecting a header byte and
//  the header codes return to 1..5. cfg_ready is always high.
//
module sign_record_stream_parser (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  record_kind,
  output logic [1:0]  group_kind,
  output logic [23:0] sign_id,
  output logic [7:0]  value_byte,
  output logic [15:0] distance,
  output logic        message_end,
  output logic        truncated,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] cfg_code [srsp_pkg::NUM_CODES];

  srsp_pkg::phase_t phase, phase_next;
  logic [2:0]  byte_position, byte_position_next;
  logic [7:0]  entries_remaining, entries_remaining_next;
  logic [1:0]  current_group, current_group_next;
  logic [23:0] id_acc, id_acc_next;
  logic [7:0]  code_hold, code_hold_next;
  logic [7:0]  distance_high, distance_high_next;

  srsp_pkg::result_t res, out_reg, skid_reg;
  logic have;
  logic body_done;
  logic skid_full;
  logic in_fire, out_fire;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_full;
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_code[srsp_pkg::REG_CUR_SPEED]  <= 8'd1;
      cfg_code[srsp_pkg::REG_NEXT_SPEED] <= 8'd2;
      cfg_code[srsp_pkg::REG_CAMERA]     <= 8'd3;
      cfg_code[srsp_pkg::REG_TRAFFIC]    <= 8'd4;
      cfg_code[srsp_pkg::REG_OTHER]      <= 8'd5;
    end else if (cfg_valid && cfg_ready && cfg_index <= srsp_pkg::REG_OTHER) begin
      cfg_code[cfg_index] <= cfg_data;
    end
  end

  // per-byte parse step
  always_comb begin
    phase_next             = phase;
    byte_position_next     = byte_position;
    entries_remaining_next = entries_remaining;
    current_group_next     = current_group;
    id_acc_next            = id_acc;
    code_hold_next         = code_hold;
    distance_high_next     = distance_high;
    res                    = '0;
    have                   = 1'b0;
    body_done              = 1'b0;

    // shared six-byte body absorber
    if (phase == srsp_pkg::PH_NEXT_BODY || phase == srsp_pkg::PH_ENTRY_BODY) begin
      if (byte_position < srsp_pkg::ID_BYTES) begin
        id_acc_next = {id_acc[15:0], data_byte};
      end else if (byte_position == srsp_pkg::POS_CODE) begin
        code_hold_next = data_byte;
      end else if (byte_position == srsp_pkg::POS_DIST_HIGH) begin
        distance_high_next = data_byte;
      end
      body_done          = byte_position >= srsp_pkg::BODY_LAST_POS;
      byte_position_next = body_done ? 3'd0 : byte_position + 3'd1;
    end

    unique case (phase)
      srsp_pkg::PH_CUR_SPEED: begin
        res.record_kind = srsp_pkg::KIND_CUR_SPEED;
        res.value_byte  = data_byte;
        have            = 1'b1;
        phase_next      = srsp_pkg::PH_HEADER;
      end
      srsp_pkg::PH_NEXT_BODY: begin
        if (body_done) begin
          res.record_kind        = srsp_pkg::KIND_NEXT_SPEED;
          res.sign_id            = id_acc_next;
          res.value_byte         = code_hold_next;
          res.distance           = {distance_high, data_byte};
          have                   = 1'b1;
          phase_next             = srsp_pkg::PH_HEADER;
          byte_position_next     = 3'd0;
          entries_remaining_next = 8'd0;
          id_acc_next            = '0;
        end
      end
      srsp_pkg::PH_COUNT: begin
        res.record_kind        = srsp_pkg::KIND_GROUP_HDR;
        res.group_kind         = current_group;
        res.value_byte         = data_byte;
        have                   = 1'b1;
        entries_remaining_next = data_byte;
        byte_position_next     = 3'd0;
        id_acc_next            = '0;
        phase_next = (data_byte == 8'd0) ? srsp_pkg::PH_HEADER : srsp_pkg::PH_ENTRY_BODY;
      end
      srsp_pkg::PH_ENTRY_BODY: begin
        if (body_done) begin
          res.record_kind        = srsp_pkg::KIND_SIGN_ENTRY;
          res.group_kind         = current_group;
          res.sign_id            = id_acc_next;
          res.value_byte         = code_hold_next;
          res.distance           = {distance_high, data_byte};
          have                   = 1'b1;
          id_acc_next            = '0;
          entries_remaining_next = entries_remaining - 8'd1;
          if (entries_remaining_next == 8'd0) begin
            phase_next = srsp_pkg::PH_HEADER;
          end
        end
      end
      default: begin
        // header byte; first matching code wins, unknown bytes are skipped
        phase_next             = srsp_pkg::PH_HEADER;
        byte_position_next     = 3'd0;
        entries_remaining_next = 8'd0;
        id_acc_next            = '0;
        priority if (data_byte == cfg_code[srsp_pkg::REG_CUR_SPEED]) begin
          phase_next = srsp_pkg::PH_CUR_SPEED;
        end else if (data_byte == cfg_code[srsp_pkg::REG_NEXT_SPEED]) begin
          phase_next = srsp_pkg::PH_NEXT_BODY;
        end else if (data_byte == cfg_code[srsp_pkg::REG_CAMERA]) begin
          current_group_next = srsp_pkg::GRP_CAMERA;
          phase_next         = srsp_pkg::PH_COUNT;
        end else if (data_byte == cfg_code[srsp_pkg::REG_TRAFFIC]) begin
          current_group_next = srsp_pkg::GRP_TRAFFIC;
          phase_next         = srsp_pkg::PH_COUNT;
        end else if (data_byte == cfg_code[srsp_pkg::REG_OTHER]) begin
          current_group_next = srsp_pkg::GRP_OTHER;
          phase_next         = srsp_pkg::PH_COUNT;
        end else begin
          phase_next = srsp_pkg::PH_HEADER;
        end
      end
    endcase

    // last byte closes the message and always restarts the parse
    if (last_byte) begin
      if (!have) begin
        res             = '0;
        res.record_kind = srsp_pkg::KIND_END_ONLY;
        have            = 1'b1;
      end
      res.message_end        = 1'b1;
      res.truncated          = phase_next != srsp_pkg::PH_HEADER;
      phase_next             = srsp_pkg::PH_HEADER;
      byte_position_next     = 3'd0;
      entries_remaining_next = 8'd0;
      id_acc_next            = '0;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= srsp_pkg::PH_HEADER;
      byte_position     <= 3'd0;
      entries_remaining <= 8'd0;
      current_group     <= 2'd0;
      id_acc            <= '0;
      code_hold         <= 8'd0;
      distance_high     <= 8'd0;
    end else if (in_fire) begin
      phase             <= phase_next;
      byte_position     <= byte_position_next;
      entries_remaining <= entries_remaining_next;
      current_group     <= current_group_next;
      id_acc            <= id_acc_next;
      code_hold         <= code_hold_next;
      distance_high     <= distance_high_next;
    end
  end

  // output register with one-deep skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_fire) begin
        skid_full <= 1'b0;
      end
    end else if (!out_valid || out_fire) begin
      out_valid <= in_fire && have;
    end else if (in_fire && have) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (out_fire) begin
        out_reg <= skid_reg;
      end
    end else if (!out_valid || out_fire) begin
      out_reg <= res;
    end else begin
      skid_reg <= res;
    end
  end

  assign record_kind = out_reg.record_kind;
  assign group_kind  = out_reg.group_kind;
  assign sign_id     = out_reg.sign_id;
  assign value_byte  = out_reg.value_byte;
  assign distance    = out_reg.distance;
  assign message_end = out_reg.message_end;
  assign truncated   = out_reg.truncated;

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid)
    else $error("skid register occupied while output register empty");

  a_header_clean: assert property (@(posedge clk) disable iff (rst)
    (phase == srsp_pkg::PH_HEADER) |-> (byte_position == 3'd0 && entries_remaining == 8'd0))
    else $error("header phase with stale body position or entry count");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= srsp_pkg::BODY_LAST_POS)
    else $error("body byte position out of range");

  a_entry_count: assert property (@(posedge clk) disable iff (rst)
    (phase == srsp_pkg::PH_ENTRY_BODY) |-> (entries_remaining != 8'd0))
    else $error("entry body with no entries remaining");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && last_byte) |=> (phase == srsp_pkg::PH_HEADER))
    else $error("parse did not restart after last byte");

  a_trunc_end: assert property (@(posedge clk) disable iff (rst)
    (in_fire && have && !skid_full && (!out_valid || out_fire) && res.truncated)
      |=> (out_valid && message_end))
    else $error("truncated result without message end");
`endif

endmodule
